[hdl/mhe_pkg.sv]
// ----------------------------------------------------------------------------
// mhe_pkg
// Shared types and constants for the min-heap extract core.
// ----------------------------------------------------------------------------
package mhe_pkg;

  // data word of one heap entry
  localparam int unsigned DATA_W = 32;
  // width of the reported entry count
  localparam int unsigned TOTAL_W = 5;

  typedef logic [DATA_W-1:0] word_t;

  // operation codes
  localparam logic OP_APPEND  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // result value returned on an empty extract
  localparam word_t UNDERFLOW_VALUE = '1;

endpackage

[hdl/mhe_ram.sv]
// ----------------------------------------------------------------------------
// mhe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mhe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/min_heap_extract_core.sv]
// ----------------------------------------------------------------------------
// min_heap_extract_core
// Binary min-heap held in one RAM: append writes after the last entry,
// extract returns the root and sifts the last entry down from the root.
// ----------------------------------------------------------------------------
// Append and empty extract give their result beat in the cycle after start;
// a real extract passes ST_ROOT, ST_LAST and ST_HOLD for root and last
// entry, then per level ST_REQ, ST_LDAT and, with a right child, ST_RDAT
// (left child, right child, decide), and ST_REQ again at a leaf. One result
// beat per operation; busy is high while an extract is running.
// Reset (rst_n low, synchronous) empties the heap; no receiver stall.
module min_heap_extract_core
  import mhe_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic               out_underflow,
  output logic               out_full_reject,
  output logic [4:0]         out_entry_total
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W  = CNT_W + 1;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROOT = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_HOLD = 3'd3;
  localparam logic [2:0] ST_REQ  = 3'd4;
  localparam logic [2:0] ST_LDAT = 3'd5;
  localparam logic [2:0] ST_RDAT = 3'd6;

  // heap position (1-based) to RAM slot
  function automatic logic [ADDR_W-1:0] slot_of(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] pm1;
    pm1 = p - POS_W'(1);
    return pm1[ADDR_W-1:0];
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  word_t             hold_r, hold_nxt;
  word_t             lval_r, lval_nxt;
  logic              out_valid_r, out_valid_nxt;
  word_t             result_r, result_nxt;
  logic              underflow_r, underflow_nxt;
  logic              reject_r, reject_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  word_t             ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  word_t             ram_rdata;

  logic [POS_W-1:0]  pos_ext;
  logic [POS_W-1:0]  left_pos;
  logic [POS_W-1:0]  right_pos;
  logic [POS_W-1:0]  count_ext;
  logic              accept;
  word_t             cand_val;
  logic [POS_W-1:0]  cand_pos;
  logic [CNT_W+4:0]  total_ext;

  mhe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept    = start && (state_r == ST_IDLE);
  assign pos_ext   = {1'b0, pos_r};
  assign left_pos  = {pos_r, 1'b0};
  assign right_pos = {pos_r, 1'b1};
  assign count_ext = {1'b0, count_r};

  // smaller child, left wins ties
  always_comb begin
    if (state_r == ST_RDAT && $signed(ram_rdata) < $signed(lval_r)) begin
      cand_val = ram_rdata;
      cand_pos = right_pos;
    end else if (state_r == ST_RDAT) begin
      cand_val = lval_r;
      cand_pos = left_pos;
    end else begin
      cand_val = ram_rdata;
      cand_pos = left_pos;
    end
  end

  // sequencer and ram control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    hold_nxt      = hold_r;
    lval_nxt      = lval_r;
    out_valid_nxt = 1'b0;
    result_nxt    = result_r;
    underflow_nxt = underflow_r;
    reject_nxt    = reject_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_of(pos_ext);
    ram_wdata     = hold_r;
    ram_raddr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_APPEND) begin
            // append beat: write after the last entry unless full
            out_valid_nxt = 1'b1;
            result_nxt    = '0;
            underflow_nxt = 1'b0;
            if (count_r >= CAP_CNT) begin
              reject_nxt = 1'b1;
            end else begin
              reject_nxt = 1'b0;
              ram_we     = 1'b1;
              ram_waddr  = count_r[ADDR_W-1:0];
              ram_wdata  = in_value;
              count_nxt  = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            // empty extract
            out_valid_nxt = 1'b1;
            result_nxt    = UNDERFLOW_VALUE;
            underflow_nxt = 1'b1;
            reject_nxt    = 1'b0;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        // read root
        ram_raddr = '0;
        state_nxt = ST_LAST;
      end
      ST_LAST: begin
        // read old last entry, capture root
        ram_raddr  = count_r[ADDR_W-1:0];
        result_nxt = ram_rdata;
        state_nxt  = ST_HOLD;
      end
      ST_HOLD: begin
        // capture the entry that sinks from the root
        hold_nxt = ram_rdata;
        pos_nxt  = CNT_W'(1);
        if (count_r == '0) begin
          out_valid_nxt = 1'b1;
          underflow_nxt = 1'b0;
          reject_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_REQ;
        end
      end
      ST_REQ: begin
        if (left_pos > count_ext) begin
          // leaf reached: place the sinking entry
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          underflow_nxt = 1'b0;
          reject_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          ram_raddr = slot_of(left_pos);
          state_nxt = ST_LDAT;
        end
      end
      ST_LDAT, ST_RDAT: begin
        if (state_r == ST_LDAT && right_pos <= count_ext) begin
          // fetch right child too
          lval_nxt  = ram_rdata;
          ram_raddr = slot_of(right_pos);
          state_nxt = ST_RDAT;
        end else if ($signed(cand_val) < $signed(hold_r)) begin
          // child moves up, continue one level down
          ram_we    = 1'b1;
          ram_wdata = cand_val;
          pos_nxt   = cand_pos[CNT_W-1:0];
          state_nxt = ST_REQ;
        end else begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          underflow_nxt = 1'b0;
          reject_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    hold_r      <= hold_nxt;
    lval_r      <= lval_nxt;
    result_r    <= result_nxt;
    underflow_r <= underflow_nxt;
    reject_r    <= reject_nxt;
  end

  // result beat
  assign total_ext        = {5'b0, count_r};
  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = result_r;
  assign out_underflow    = underflow_r;
  assign out_full_reject  = reject_r;
  assign out_entry_total  = total_ext[4:0];

endmodule
